// ===== rtl/core/lhm_pkg.sv =====
// link health monitor: shared types, constants and register codes
// no dependencies; used by the interfaces and every module of the block
package lhm_pkg;

    // field and counter widths
    localparam int unsigned TIMER_W       = 20;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned CMD_W         = 3;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 20;
    localparam int unsigned SEQ_BITS_DEF  = 16;

    // register reset values and timer ceiling
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);
    localparam logic [TIMER_W-1:0] SILENCE_MAX   = {TIMER_W{1'b1}};
    localparam logic               CAN_FWD_RESET = 1'b1;

    // event kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_FRAME    = 3'd1,
        CMD_CRC      = 3'd2,
        CMD_FORMAT   = 3'd3,
        CMD_OVERFLOW = 3'd4
    } cmd_t;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAN_FORWARDING = 1'b1;

    // live configuration
    typedef struct packed {
        logic [TIMER_W-1:0] timeout_ms;
        logic               can_forwarding;
    } cfg_t;

    // one result of the monitor
    typedef struct packed {
        logic               timed_out;
        logic               timeout_event;
        logic               recovered_event;
        logic [COUNT_W-1:0] valid_count;
        logic [COUNT_W-1:0] lost_count;
        logic [COUNT_W-1:0] crc_count;
        logic [COUNT_W-1:0] format_count;
        logic [COUNT_W-1:0] overflow_count;
        logic [COUNT_W-1:0] can_fail_count;
    } result_t;

endpackage

// ===== rtl/core/lhm_if.sv =====
// link health monitor: request and report channel interfaces
// depends on lhm_pkg for widths
interface lhm_item_if #(
    parameter int unsigned SEQUENCE_BITS = lhm_pkg::SEQ_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [lhm_pkg::CMD_W-1:0]       command;
    logic [SEQUENCE_BITS-1:0]        sequence_req;
    logic                            can_sent;

    modport source (output valid, command, sequence_req, can_sent, input ready);
    modport sink   (input valid, command, sequence_req, can_sent, output ready);
endinterface

interface lhm_report_if;
    logic                            valid;
    logic                            ready;
    logic                            timed_out;
    logic                            timeout_event;
    logic                            recovered_event;
    logic [lhm_pkg::COUNT_W-1:0]     valid_count;
    logic [lhm_pkg::COUNT_W-1:0]     lost_count;
    logic [lhm_pkg::COUNT_W-1:0]     crc_count;
    logic [lhm_pkg::COUNT_W-1:0]     format_count;
    logic [lhm_pkg::COUNT_W-1:0]     overflow_count;
    logic [lhm_pkg::COUNT_W-1:0]     can_fail_count;

    modport source (output valid, timed_out, timeout_event, recovered_event, valid_count,
                    lost_count, crc_count, format_count, overflow_count, can_fail_count,
                    input ready);
    modport sink   (input valid, timed_out, timeout_event, recovered_event, valid_count,
                    lost_count, crc_count, format_count, overflow_count, can_fail_count,
                    output ready);
endinterface

// ===== rtl/core/lhm_cfg.sv =====
// link health monitor: configuration registers behind the write port
// depends on lhm_pkg
module lhm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [lhm_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]      wr_data,
    output lhm_pkg::cfg_t                       cfg
);

    lhm_pkg::cfg_t cfg_reg;
    lhm_pkg::cfg_t cfg_next;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                lhm_pkg::REG_TIMEOUT_MS:
                    cfg_next.timeout_ms = wr_data[lhm_pkg::TIMER_W-1:0];
                lhm_pkg::REG_CAN_FORWARDING:
                    cfg_next.can_forwarding = wr_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms     <= lhm_pkg::TIMEOUT_RESET;
            cfg_reg.can_forwarding <= lhm_pkg::CAN_FWD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lhm_update.sv =====
// link health monitor: link state, counters and the per-request update
// depends on lhm_pkg; fed from the top level's request register
module lhm_update #(
    parameter int unsigned SEQUENCE_BITS = lhm_pkg::SEQ_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [lhm_pkg::CMD_W-1:0]       command,
    input  logic [SEQUENCE_BITS-1:0]        sequence_req,
    input  logic                            can_sent,
    input  lhm_pkg::cfg_t                   cfg,
    output lhm_pkg::result_t                result
);

    localparam int unsigned LOSS_W = SEQUENCE_BITS - 1;
    localparam logic [SEQUENCE_BITS-1:0] HALF = {1'b1, {LOSS_W{1'b0}}};
    localparam logic [SEQUENCE_BITS-1:0] ONE  = SEQUENCE_BITS'(1);

    logic [lhm_pkg::TIMER_W-1:0]  silence_reg,  silence_next;
    logic [SEQUENCE_BITS-1:0]     prev_seq_reg, prev_seq_next;
    logic                         seen_reg,     seen_next;
    logic                         down_reg,     down_next;
    logic [lhm_pkg::COUNT_W-1:0]  valid_reg,    valid_next;
    logic [lhm_pkg::COUNT_W-1:0]  lost_reg,     lost_next;
    logic [lhm_pkg::COUNT_W-1:0]  crc_reg,      crc_next;
    logic [lhm_pkg::COUNT_W-1:0]  format_reg,   format_next;
    logic [lhm_pkg::COUNT_W-1:0]  overflow_reg, overflow_next;
    logic [lhm_pkg::COUNT_W-1:0]  canfail_reg,  canfail_next;

    logic [SEQUENCE_BITS-1:0]     delta;
    logic [SEQUENCE_BITS-1:0]     gap;
    logic                         gap_counts;
    logic                         down_mid;
    logic                         recovered;
    logic                         entered;

    // sequence gap, modulo the sequence width
    assign delta      = sequence_req - prev_seq_reg;
    assign gap        = delta - ONE;
    assign gap_counts = seen_reg && (delta > ONE) && (delta < HALF);

    // event decode
    always_comb
    begin
        silence_next  = silence_reg;
        prev_seq_next = prev_seq_reg;
        seen_next     = seen_reg;
        down_mid      = down_reg;
        recovered     = 1'b0;
        valid_next    = valid_reg;
        lost_next     = lost_reg;
        crc_next      = crc_reg;
        format_next   = format_reg;
        overflow_next = overflow_reg;
        canfail_next  = canfail_reg;
        unique case (lhm_pkg::cmd_t'(command))
            lhm_pkg::CMD_TICK:
            begin
                if (silence_reg != lhm_pkg::SILENCE_MAX)
                begin
                    silence_next = silence_reg + 1'b1;
                end
            end
            lhm_pkg::CMD_FRAME:
            begin
                valid_next = valid_reg + 1'b1;
                if (gap_counts)
                begin
                    lost_next = lost_reg + lhm_pkg::COUNT_W'(gap[LOSS_W-1:0]);
                end
                prev_seq_next = sequence_req;
                seen_next     = 1'b1;
                silence_next  = '0;
                down_mid      = 1'b0;
                recovered     = down_reg;
                if (cfg.can_forwarding && !can_sent)
                begin
                    canfail_next = canfail_reg + 1'b1;
                end
            end
            lhm_pkg::CMD_CRC:
                crc_next = crc_reg + 1'b1;
            lhm_pkg::CMD_FORMAT:
                format_next = format_reg + 1'b1;
            lhm_pkg::CMD_OVERFLOW:
                overflow_next = overflow_reg + 1'b1;
            default:
                silence_next = silence_reg;
        endcase
    end

    // timeout check after the event
    assign entered   = !down_mid && (silence_next > cfg.timeout_ms);
    assign down_next = down_mid || entered;

    // result of this request
    always_comb
    begin
        result.timed_out       = down_next;
        result.timeout_event   = entered;
        result.recovered_event = recovered;
        result.valid_count     = valid_next;
        result.lost_count      = lost_next;
        result.crc_count       = crc_next;
        result.format_count    = format_next;
        result.overflow_count  = overflow_next;
        result.can_fail_count  = canfail_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg  <= '0;
            prev_seq_reg <= '0;
            seen_reg     <= 1'b0;
            down_reg     <= 1'b0;
            valid_reg    <= '0;
            lost_reg     <= '0;
            crc_reg      <= '0;
            format_reg   <= '0;
            overflow_reg <= '0;
            canfail_reg  <= '0;
        end
        else if (step)
        begin
            silence_reg  <= silence_next;
            prev_seq_reg <= prev_seq_next;
            seen_reg     <= seen_next;
            down_reg     <= down_next;
            valid_reg    <= valid_next;
            lost_reg     <= lost_next;
            crc_reg      <= crc_next;
            format_reg   <= format_next;
            overflow_reg <= overflow_next;
            canfail_reg  <= canfail_next;
        end
    end

endmodule

// ===== rtl/core/link_health_monitor_top.sv =====
// link health monitor: top level with request register and report register
// depends on lhm_pkg, lhm_if, lhm_cfg and lhm_update
//
// Usage:
//   item   - request channel (valid/ready): command, sequence_req, can_sent.
//            command is tick, valid frame, CRC error, format error or overflow.
//   report - report channel (valid/ready): one report for every request,
//            carrying the timeout flags and the six wrapping 32-bit counters.
//   wr_en / wr_index / wr_data - register writes (timeout_ms, can_forwarding),
//            taken at any clock edge with wr_en high; write only while idle.
// Path: an accepted request passes through the request register, then the
//   report register, which holds its report.
// Throughput: one request per clock while report.ready holds; the link state
//   updates per request, so each request sees the state left by the one before it.
// Reset: all counters, the silence timer and the link state clear;
//   timeout_ms returns to 1000 ms and can_forwarding to 1.
// Stall: when the report is not taken, the report register holds it and the
//   request register fills once; item.ready then drops until report.ready.
module link_health_monitor_top #(
    parameter int unsigned SEQUENCE_BITS = lhm_pkg::SEQ_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lhm_item_if.sink                            item,
    lhm_report_if.source                        report,
    input  logic                                wr_en,
    input  logic [lhm_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]      wr_data
);

    lhm_pkg::cfg_t                  cfg;
    lhm_pkg::result_t               result;
    lhm_pkg::result_t               report_reg;
    logic                           report_valid_reg;
    logic                           in_valid_reg;
    logic [lhm_pkg::CMD_W-1:0]      command_reg;
    logic [SEQUENCE_BITS-1:0]       sequence_reg;
    logic                           can_sent_reg;
    logic                           advance;
    logic                           step;

    // flow control
    assign advance    = !report_valid_reg || report.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            command_reg  <= item.command;
            sequence_reg <= item.sequence_req;
            can_sent_reg <= item.can_sent;
        end
    end

    lhm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    lhm_update #(
        .SEQUENCE_BITS (SEQUENCE_BITS)
    ) u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .command      (command_reg),
        .sequence_req (sequence_reg),
        .can_sent     (can_sent_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            report_reg <= result;
        end
    end

    // report channel
    assign report.valid           = report_valid_reg;
    assign report.timed_out       = report_reg.timed_out;
    assign report.timeout_event   = report_reg.timeout_event;
    assign report.recovered_event = report_reg.recovered_event;
    assign report.valid_count     = report_reg.valid_count;
    assign report.lost_count      = report_reg.lost_count;
    assign report.crc_count       = report_reg.crc_count;
    assign report.format_count    = report_reg.format_count;
    assign report.overflow_count  = report_reg.overflow_count;
    assign report.can_fail_count  = report_reg.can_fail_count;

endmodule
